FILE: src/argb2222_rect_overlay_unit_macros.svh
// Assertion macros for the ARGB2222 rectangle overlay unit.
// Taken in by the top-level RTL file, which carries the concurrent checks; no other dependencies.
`ifndef ARGB2222_RECT_OVERLAY_UNIT_MACROS_SVH
`define ARGB2222_RECT_OVERLAY_UNIT_MACROS_SVH

// Check a property on every rising edge, skipped while reset is high.
`define ARO_CHECK(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("overlay check failed");

// Check a property on every rising edge, reset included.
`define ARO_CHECK_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("overlay check failed");

`endif

FILE: src/aro_pkg.sv
// Shared types, register indexes and colour helpers for the overlay unit.
// No dependencies.
`timescale 1ns / 1ps

package aro_pkg;

   localparam int unsigned POS_W   = 8;
   localparam int unsigned PIX_W   = 8;
   localparam int unsigned COORD_W = 16;
   localparam int unsigned CSR_AW  = 3;

   typedef enum logic [CSR_AW-1:0] {
      REG_RECT_LEFT    = 3'd0,
      REG_RECT_TOP     = 3'd1,
      REG_RECT_WIDTH   = 3'd2,
      REG_RECT_HEIGHT  = 3'd3,
      REG_FILL_COLOR   = 3'd4,
      REG_OVERLAY_MODE = 3'd5
   } csr_index_type;

   localparam logic MODE_BLEND = 1'b0;
   localparam logic MODE_SHADE = 1'b1;

   localparam logic [1:0] ALPHA_OPAQUE = 2'b11;
   localparam logic [PIX_W-1:0] FILL_RESET = 8'hFF;

   // Clipped window and colour settings seen by the pixel datapath
   typedef struct packed {
      logic [POS_W-1:0] x1;
      logic [POS_W-1:0] x2;
      logic [POS_W-1:0] y1;
      logic [POS_W-1:0] y2;
      logic [PIX_W-1:0] fill;
      logic             mode;
   } window_type;

   // Contents of the input stage register
   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic [POS_W-1:0] col;
      logic [POS_W-1:0] row;
   } stage_type;

   // Clamp a signed 17-bit coordinate to [0, hi]
   function automatic logic [POS_W-1:0] clamp_coord(input logic signed [COORD_W:0] v,
                                                    input logic [POS_W-1:0] hi);
      logic [POS_W-1:0] res;
      if (v[COORD_W]) begin
         res = '0;
      end else if (v[COORD_W-1:0] > {{(COORD_W-POS_W){1'b0}}, hi}) begin
         res = hi;
      end else begin
         res = v[POS_W-1:0];
      end
      return res;
   endfunction

   // max(c - d, 0) on a 2-bit channel
   function automatic logic [1:0] sat_sub2(input logic [1:0] c, input logic [1:0] d);
      return (c > d) ? (c - d) : 2'b00;
   endfunction

   // Sum of two channel terms known never to exceed 3
   function automatic logic [1:0] add2(input logic [1:0] a, input logic [1:0] b);
      logic [2:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[1:0];
   endfunction

endpackage

FILE: src/aro_csr.sv
// Configuration registers and rectangle clipping for the overlay unit.
// Depends on aro_pkg.
`timescale 1ns / 1ps

module aro_csr #(
   parameter int unsigned SCREEN_WIDTH  = 144,
   parameter int unsigned SCREEN_HEIGHT = 168
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [aro_pkg::CSR_AW-1:0]          csr_addr,
   input  logic [aro_pkg::COORD_W-1:0]         csr_wdata,
   output aro_pkg::window_type                 window
);

   logic [aro_pkg::COORD_W-1:0] left_ff, top_ff, width_ff, height_ff;
   logic [aro_pkg::PIX_W-1:0]   fill_ff;
   logic                        mode_ff;

   logic signed [aro_pkg::COORD_W:0] left_ext, top_ext, right_sum, bottom_sum;
   logic [aro_pkg::POS_W-1:0]        scr_w, scr_h;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         top_ff    <= '0;
         width_ff  <= '0;
         height_ff <= '0;
         fill_ff   <= aro_pkg::FILL_RESET;
         mode_ff   <= aro_pkg::MODE_BLEND;
      end else if (csr_we) begin
         unique case (aro_pkg::csr_index_type'(csr_addr))
            aro_pkg::REG_RECT_LEFT:    left_ff   <= csr_wdata;
            aro_pkg::REG_RECT_TOP:     top_ff    <= csr_wdata;
            aro_pkg::REG_RECT_WIDTH:   width_ff  <= csr_wdata;
            aro_pkg::REG_RECT_HEIGHT:  height_ff <= csr_wdata;
            aro_pkg::REG_FILL_COLOR:   fill_ff   <= csr_wdata[aro_pkg::PIX_W-1:0];
            aro_pkg::REG_OVERLAY_MODE: mode_ff   <= csr_wdata[0];
            default: begin
               // drop writes to unused indexes
            end
         endcase
      end
   end

   // Far edges are summed at full precision, then everything is clamped
   always_comb begin
      scr_w      = aro_pkg::POS_W'(SCREEN_WIDTH);
      scr_h      = aro_pkg::POS_W'(SCREEN_HEIGHT);
      left_ext   = {left_ff[aro_pkg::COORD_W-1], left_ff};
      top_ext    = {top_ff[aro_pkg::COORD_W-1], top_ff};
      right_sum  = left_ext + {width_ff[aro_pkg::COORD_W-1], width_ff};
      bottom_sum = top_ext + {height_ff[aro_pkg::COORD_W-1], height_ff};
      window.x1   = aro_pkg::clamp_coord(left_ext, scr_w);
      window.x2   = aro_pkg::clamp_coord(right_sum, scr_w);
      window.y1   = aro_pkg::clamp_coord(top_ext, scr_h);
      window.y2   = aro_pkg::clamp_coord(bottom_sum, scr_h);
      window.fill = fill_ff;
      window.mode = mode_ff;
   end

endmodule

FILE: src/aro_pos.sv
// Raster position tracking and input stage register for the overlay unit.
// Depends on aro_pkg.
`timescale 1ns / 1ps

module aro_pos #(
   parameter int unsigned SCREEN_WIDTH  = 144,
   parameter int unsigned SCREEN_HEIGHT = 168
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [aro_pkg::PIX_W-1:0]    req_pixel_in,
   input  logic                         req_frame_start,
   input  logic                         stage_ready,
   output logic                         stage_valid,
   output aro_pkg::stage_type           stage
);

   logic [aro_pkg::POS_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [aro_pkg::POS_W-1:0] col_cur, row_cur;
   logic [aro_pkg::POS_W:0]   col_inc, row_inc;
   logic                      st_valid_ff, st_valid_in;
   aro_pkg::stage_type        st_ff, st_in;
   logic                      take;

   assign req_ready = !st_valid_ff || stage_ready;
   assign take      = req_valid && req_ready;

   always_comb begin
      col_cur = req_frame_start ? '0 : col_ff;
      row_cur = req_frame_start ? '0 : row_ff;
      col_inc = {1'b0, col_cur} + 1'b1;
      row_inc = {1'b0, row_cur} + 1'b1;
      col_in  = col_ff;
      row_in  = row_ff;
      if (take) begin
         if (col_inc >= (aro_pkg::POS_W+1)'(SCREEN_WIDTH)) begin
            // end of line: wrap the column and advance the row
            col_in = '0;
            row_in = (row_inc >= (aro_pkg::POS_W+1)'(SCREEN_HEIGHT)) ? '0
                                                                   : row_inc[aro_pkg::POS_W-1:0];
         end else begin
            col_in = col_inc[aro_pkg::POS_W-1:0];
            row_in = row_cur;
         end
      end
      st_valid_in = take ? 1'b1 : (stage_ready ? 1'b0 : st_valid_ff);
      st_in       = st_ff;
      if (take) begin
         st_in.pixel = req_pixel_in;
         st_in.col   = col_cur;
         st_in.row   = row_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         st_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         st_valid_ff <= st_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      st_ff <= st_in;
   end

   assign stage_valid = st_valid_ff;
   assign stage       = st_ff;

endmodule

FILE: src/aro_pix.sv
// Window test and ARGB2222 blend/shade datapath for one pixel.
// Depends on aro_pkg.
`timescale 1ns / 1ps

module aro_pix (
   input  aro_pkg::stage_type           stage,
   input  aro_pkg::window_type          window,
   output logic [aro_pkg::PIX_W-1:0]    pixel_out,
   output logic                         in_window
);

   logic [1:0] fill_a, pix_a, blend_drop, fg_drop, shade_lvl;
   logic [1:0] bg_ch, fg_ch;
   logic [aro_pkg::PIX_W-1:0] blended, shaded;

   always_comb begin
      in_window = (stage.col >= window.x1) && (stage.col < window.x2) &&
                  (stage.row >= window.y1) && (stage.row < window.y2);

      fill_a     = window.fill[7:6];
      pix_a      = stage.pixel[7:6];
      blend_drop = fill_a;
      fg_drop    = ~fill_a;
      shade_lvl  = fill_a & pix_a;

      blended      = '0;
      shaded       = '0;
      blended[7:6] = aro_pkg::ALPHA_OPAQUE;
      shaded[7:6]  = aro_pkg::ALPHA_OPAQUE;
      for (int i = 0; i < 3; i++) begin
         bg_ch = aro_pkg::sat_sub2(stage.pixel[2*i +: 2], blend_drop);
         fg_ch = aro_pkg::sat_sub2(window.fill[2*i +: 2], fg_drop);
         blended[2*i +: 2] = aro_pkg::add2(bg_ch, fg_ch);
         shaded[2*i +: 2]  = aro_pkg::sat_sub2(stage.pixel[2*i +: 2], ~shade_lvl);
      end

      if (!in_window) begin
         pixel_out = stage.pixel;
      end else if (window.mode == aro_pkg::MODE_SHADE) begin
         pixel_out = shaded;
      end else begin
         pixel_out = blended;
      end
   end

endmodule

FILE: src/argb2222_rect_overlay_unit.sv
// ARGB2222 rectangle overlay unit: top level with result register and checks.
// Depends on aro_pkg, aro_csr, aro_pos, aro_pix and the macros header.
`timescale 1ns / 1ps
`include "argb2222_rect_overlay_unit_macros.svh"

// Pixels arrive in raster order, one transaction each, and leave in the same
// order with their window flag. One pixel is taken per clock while req_ready is
// high; each passes the input stage register, then the result register, so a
// result is offered from the result register once its pixel has moved on from
// the stage register, and is taken when rsp_ready is high. With the output
// stalled the unit holds two pixels and then drops req_ready.
// The column/row counters advance on every accepted pixel and frame_start forces
// the current pixel to column 0, row 0. Write the configuration registers only
// while no pixel is in flight; the clipped window follows a write at once.

module argb2222_rect_overlay_unit #(
   parameter int unsigned SCREEN_WIDTH  = 144,
   parameter int unsigned SCREEN_HEIGHT = 168
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [aro_pkg::PIX_W-1:0]    req_pixel_in,
   input  logic                         req_frame_start,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [aro_pkg::PIX_W-1:0]    rsp_pixel_out,
   output logic                         rsp_in_window,
   input  logic                         csr_we,
   input  logic [aro_pkg::CSR_AW-1:0]   csr_addr,
   input  logic [aro_pkg::COORD_W-1:0]  csr_wdata
);

   localparam logic [aro_pkg::POS_W-1:0] COL_LIMIT = aro_pkg::POS_W'(SCREEN_WIDTH);
   localparam logic [aro_pkg::POS_W-1:0] ROW_LIMIT = aro_pkg::POS_W'(SCREEN_HEIGHT);

   aro_pkg::window_type       window;
   aro_pkg::stage_type        stage;
   logic                      stage_valid, stage_ready;
   logic [aro_pkg::PIX_W-1:0] pix_res;
   logic                      win_res;

   logic                      out_valid_ff, out_valid_in;
   logic [aro_pkg::PIX_W-1:0] out_pixel_ff, out_pixel_in;
   logic                      out_win_ff, out_win_in;
   logic                      load_out;

   logic                      pass_load, fill_load, origin_take, pos_ok;

   aro_csr #(
      .SCREEN_WIDTH (SCREEN_WIDTH),
      .SCREEN_HEIGHT(SCREEN_HEIGHT)
   ) u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_addr (csr_addr),
      .csr_wdata(csr_wdata),
      .window   (window)
   );

   aro_pos #(
      .SCREEN_WIDTH (SCREEN_WIDTH),
      .SCREEN_HEIGHT(SCREEN_HEIGHT)
   ) u_pos (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel_in   (req_pixel_in),
      .req_frame_start(req_frame_start),
      .stage_ready    (stage_ready),
      .stage_valid    (stage_valid),
      .stage          (stage)
   );

   aro_pix u_pix (
      .stage    (stage),
      .window   (window),
      .pixel_out(pix_res),
      .in_window(win_res)
   );

   // Result register: free when empty or when its transaction is taken
   assign stage_ready = !out_valid_ff || rsp_ready;
   assign load_out    = stage_valid && stage_ready;

   always_comb begin
      out_valid_in = load_out ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
      out_pixel_in = load_out ? pix_res : out_pixel_ff;
      out_win_in   = load_out ? win_res : out_win_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_pixel_ff <= out_pixel_in;
      out_win_ff   <= out_win_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_pixel_out = out_pixel_ff;
   assign rsp_in_window = out_win_ff;

   assign pass_load   = load_out && !win_res;
   assign fill_load   = load_out && win_res;
   assign origin_take = req_valid && req_ready && req_frame_start;
   assign pos_ok      = (stage.col < COL_LIMIT) && (stage.row < ROW_LIMIT);

   `ARO_CHECK(a_outside_passes, clock, reset, pass_load |=> (rsp_pixel_out == $past(stage.pixel)))
   `ARO_CHECK(a_inside_opaque, clock, reset, fill_load |=> (rsp_pixel_out[7:6] == 2'b11))
   `ARO_CHECK(a_frame_origin, clock, reset, origin_take |=> (stage.col == '0 && stage.row == '0))
   `ARO_CHECK(a_pos_on_screen, clock, reset, stage_valid |-> pos_ok)

endmodule

FILE: test/argb2222_rect_overlay_unit_tb.sv
// Self-checking testbench for the ARGB2222 rectangle overlay unit.
// Depends on aro_pkg and the argb2222_rect_overlay_unit top level.
`timescale 1ns / 1ps

module argb2222_rect_overlay_unit_tb;

   localparam int SCREEN_W = 144;
   localparam int SCREEN_H = 168;
   localparam int MAX_PRINTED = 100;
   // indexes past the register map, writes there must be ignored
   localparam logic [aro_pkg::CSR_AW-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [aro_pkg::CSR_AW-1:0] REG_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [aro_pkg::PIX_W-1:0] pixel;
      logic                      in_window;
   } overlay_pixel_type;

   class overlay_scoreboard;
      logic signed [aro_pkg::COORD_W-1:0] left, top, width, height;
      logic [aro_pkg::PIX_W-1:0] fill;
      logic                      mode;
      logic [aro_pkg::POS_W-1:0] col, row;
      overlay_pixel_type         expected_q[$];
      int                        mismatches;

      function new();
         left = '0; top = '0; width = '0; height = '0;
         fill = aro_pkg::FILL_RESET; mode = aro_pkg::MODE_BLEND;
         col = '0; row = '0;
         mismatches = 0;
      endfunction

      function void set_register(logic [aro_pkg::CSR_AW-1:0] idx,
                                 logic [aro_pkg::COORD_W-1:0] data);
         case (idx)
            aro_pkg::REG_RECT_LEFT:    left = data;
            aro_pkg::REG_RECT_TOP:     top = data;
            aro_pkg::REG_RECT_WIDTH:   width = data;
            aro_pkg::REG_RECT_HEIGHT:  height = data;
            aro_pkg::REG_FILL_COLOR:   fill = data[aro_pkg::PIX_W-1:0];
            aro_pkg::REG_OVERLAY_MODE: mode = data[0];
            default: ;
         endcase
      endfunction

      function int clip_coord(int v, int hi);
         return (v < 0) ? 0 : ((v > hi) ? hi : v);
      endfunction

      function logic [1:0] floor_sub(logic [1:0] c, logic [1:0] d);
         int diff;
         diff = int'(c) - int'(d);
         return (diff < 0) ? 2'd0 : diff[1:0];
      endfunction

      function void note_pixel(logic [aro_pkg::PIX_W-1:0] pix, logic frame_start);
         int x1, x2, y1, y2, next_col, next_row;
         logic [1:0] a, l, bg, fg;
         overlay_pixel_type res;
         if (frame_start) begin
            col = '0;
            row = '0;
         end
         x1 = clip_coord(int'(left), SCREEN_W);
         x2 = clip_coord(int'(left) + int'(width), SCREEN_W);
         y1 = clip_coord(int'(top), SCREEN_H);
         y2 = clip_coord(int'(top) + int'(height), SCREEN_H);
         res.in_window = (int'(col) >= x1) && (int'(col) < x2) &&
                         (int'(row) >= y1) && (int'(row) < y2);
         res.pixel = pix;
         if (res.in_window) begin
            res.pixel[7:6] = aro_pkg::ALPHA_OPAQUE;
            a = fill[7:6];
            l = fill[7:6] & pix[7:6];
            for (int k = 0; k < 3; k++) begin
               bg = pix[2*k +: 2];
               fg = fill[2*k +: 2];
               if (mode == aro_pkg::MODE_SHADE) begin
                  res.pixel[2*k +: 2] = floor_sub(bg, 2'd3 - l);
               end else begin
                  res.pixel[2*k +: 2] = floor_sub(bg, a) + floor_sub(fg, 2'd3 - a);
               end
            end
         end
         expected_q.push_back(res);
         // advance the raster position, wrapping at the screen edges
         next_col = int'(col) + 1;
         next_row = int'(row);
         if (next_col >= SCREEN_W) begin
            next_col = 0;
            next_row++;
            if (next_row >= SCREEN_H) next_row = 0;
         end
         col = next_col[aro_pkg::POS_W-1:0];
         row = next_row[aro_pkg::POS_W-1:0];
      endfunction

      task report_mismatch(string what);
         if (mismatches < MAX_PRINTED) $display("%0t ns: mismatch: %s", $time, what);
         mismatches++;
      endtask

      task check_result(logic [aro_pkg::PIX_W-1:0] pix, logic win);
         overlay_pixel_type exp_px;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected pixel %02h", pix));
         end else begin
            exp_px = expected_q.pop_front();
            if (pix !== exp_px.pixel)
               report_mismatch($sformatf("pixel_out %02h, want %02h", pix, exp_px.pixel));
            if (win !== exp_px.in_window)
               report_mismatch($sformatf("in_window %b, want %b", win, exp_px.in_window));
         end
      endtask
   endclass

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [aro_pkg::PIX_W-1:0]    req_pixel_in = '0;
   logic                         req_frame_start = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [aro_pkg::PIX_W-1:0]    rsp_pixel_out;
   logic                         rsp_in_window;
   logic                         csr_we = 1'b0;
   logic [aro_pkg::CSR_AW-1:0]   csr_addr = '0;
   logic [aro_pkg::COORD_W-1:0]  csr_wdata = '0;

   logic                stall_rsp = 1'b0;
   int                  send_idle_pct = 0;
   int                  recv_idle_pct = 0;
   overlay_scoreboard   sb;

   argb2222_rect_overlay_unit #(
      .SCREEN_WIDTH  (SCREEN_W),
      .SCREEN_HEIGHT (SCREEN_H)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel_in    (req_pixel_in),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_out   (rsp_pixel_out),
      .rsp_in_window   (rsp_in_window),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Result side: check each accepted transaction, then pick the next ready
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_pixel_out, rsp_in_window);
      rsp_ready <= stall_rsp ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic hold_rsp_off(input int cycles);
      stall_rsp <= 1'b1;
      repeat (cycles) @(posedge clock);
      stall_rsp <= 1'b0;
   endtask

   // Offer one pixel, returning at the edge where it is accepted
   task automatic send_pixel(input logic [aro_pkg::PIX_W-1:0] pix, input logic frame_start);
      int gap;
      gap = 0;
      while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel_in <= pix;
      req_frame_start <= frame_start;
      do @(posedge clock); while (!req_ready);
      sb.note_pixel(pix, frame_start);
   endtask

   // Drop valid and hold until every expected pixel has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      while (sb.expected_q.size() > 0) @(posedge clock);
   endtask

   task automatic write_settings(input int l, input int t, input int w, input int h,
                                 input logic [aro_pkg::PIX_W-1:0] fill, input logic mode);
      logic [aro_pkg::CSR_AW-1:0]  idx[8];
      logic [aro_pkg::COORD_W-1:0] data[8];
      drain_results();
      idx[0] = aro_pkg::REG_RECT_LEFT;    data[0] = 16'(l);
      idx[1] = aro_pkg::REG_RECT_TOP;     data[1] = 16'(t);
      idx[2] = aro_pkg::REG_RECT_WIDTH;   data[2] = 16'(w);
      idx[3] = aro_pkg::REG_RECT_HEIGHT;  data[3] = 16'(h);
      idx[4] = aro_pkg::REG_FILL_COLOR;   data[4] = {8'($urandom), fill};
      idx[5] = aro_pkg::REG_OVERLAY_MODE; data[5] = {15'($urandom), mode};
      idx[6] = REG_SPARE_LO;              data[6] = 16'($urandom);
      idx[7] = REG_SPARE_HI;              data[7] = 16'($urandom);
      for (int i = 0; i < 8; i++) begin
         csr_we <= 1'b1;
         csr_addr <= idx[i];
         csr_wdata <= data[i];
         sb.set_register(idx[i], data[i]);
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   function automatic int pick_extreme();
      case ($urandom_range(3))
         0: return -32768;
         1: return 32767;
         2: return 0;
         default: return -1;
      endcase
   endfunction

   task automatic run_segment(input int n_items, input bit with_hold);
      int l, t, w, h, sel;
      bit restart;
      sel = $urandom_range(9);
      if (sel == 0) begin
         l = $signed(16'($urandom)); t = $signed(16'($urandom));
         w = $signed(16'($urandom)); h = $signed(16'($urandom));
      end else if (sel == 1) begin
         l = pick_extreme(); t = pick_extreme(); w = pick_extreme(); h = pick_extreme();
      end else begin
         // mostly windows that the early rows of a frame actually reach
         l = int'($urandom_range(180)) - 20;
         w = int'($urandom_range(170)) - 10;
         t = int'($urandom_range(18)) - 4;
         h = int'($urandom_range(20)) - 4;
      end
      write_settings(l, t, w, h, 8'($urandom), 1'($urandom));
      if (with_hold) fork hold_rsp_off(300); join_none
      restart = $urandom_range(1);
      for (int i = 0; i < n_items; i++)
         send_pixel(8'($urandom), (i == 0 && restart) || ($urandom_range(199) == 0));
   endtask

   initial begin
      #20_000_000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings give an empty window
      send_pixel(8'h00, 1'b1);
      send_pixel(8'hFF, 1'b0);
      send_pixel(8'h5A, 1'b1);
      // full-screen blend at every fill alpha
      for (int a = 0; a < 4; a++) begin
         write_settings(0, 0, SCREEN_W, SCREEN_H, {2'(a), 6'b100111}, aro_pkg::MODE_BLEND);
         send_pixel(8'h00, 1'b1);
         send_pixel(8'hFF, 1'b0);
         send_pixel(8'h3C, 1'b0);
      end
      // shade with full and partial alpha
      write_settings(0, 0, SCREEN_W, SCREEN_H, 8'hC0, aro_pkg::MODE_SHADE);
      send_pixel(8'hFF, 1'b1);
      send_pixel(8'h6E, 1'b0);
      send_pixel(8'h15, 1'b0);
      write_settings(0, 0, SCREEN_W, SCREEN_H, 8'h7F, aro_pkg::MODE_SHADE);
      send_pixel(8'hFF, 1'b1);
      send_pixel(8'hAA, 1'b0);
      // extreme coordinates, clipped without 16-bit wrap
      write_settings(-32768, -32768, 32767, 32767, 8'h00, aro_pkg::MODE_BLEND);
      send_pixel(8'hC3, 1'b1);
      write_settings(32767, 32767, 32767, 32767, 8'hFF, aro_pkg::MODE_BLEND);
      send_pixel(8'h3C, 1'b1);
      // one column wide window: edges are inclusive left, exclusive right
      write_settings(1, 0, 1, 1, 8'h9B, aro_pkg::MODE_BLEND);
      send_pixel(8'h12, 1'b1);
      send_pixel(8'h34, 1'b0);
      send_pixel(8'h56, 1'b0);
      // inverted rectangle changes nothing
      write_settings(5, 0, -3, 4, 8'hFF, aro_pkg::MODE_SHADE);
      send_pixel(8'hFF, 1'b1);

      send_idle_pct = 30; recv_idle_pct = 54;
      run_segment(270, 1'b1);
      run_segment(270, 1'b0);
      send_idle_pct = 54; recv_idle_pct = 30;
      run_segment(270, 1'b0);
      run_segment(270, 1'b0);
      send_idle_pct = 0; recv_idle_pct = 0;
      run_segment(270, 1'b0);
      run_segment(270, 1'b0);

      drain_results();
      repeat (10) @(posedge clock);
      if (sb.expected_q.size() > 0)
         sb.report_mismatch($sformatf("%0d pixels never came back", sb.expected_q.size()));
      if (sb.mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
